FILE: sv/itp_pkg.sv
`timescale 1ns / 1ps

package itp_pkg;

    localparam int CHAR_W = 8;
    localparam int ERR_W  = 2;
    localparam int RANK_W = 4;

    // Error codes carried with a result
    localparam logic [ERR_W-1:0] ERR_NONE      = 2'd0;
    localparam logic [ERR_W-1:0] ERR_OVERFLOW  = 2'd1;
    localparam logic [ERR_W-1:0] ERR_UNMATCHED = 2'd2;

    // Characters with a meaning of their own
    localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_MUL   = 8'h2A;
    localparam logic [CHAR_W-1:0] CH_DIV   = 8'h2F;
    localparam logic [CHAR_W-1:0] CH_POW   = 8'h5E;
    localparam logic [CHAR_W-1:0] CH_OPEN  = 8'h28;
    localparam logic [CHAR_W-1:0] CH_CLOSE = 8'h29;
    localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;

    // Request from the sequencer to the result stage
    typedef struct packed {
        logic              put;
        logic [CHAR_W-1:0] ch;
        logic [ERR_W-1:0]  err;
        logic              close;
        logic              done;
    } emit_req_t;

    // Room status from the result stage
    typedef struct packed {
        logic put_ok;
        logic close_ok;
    } emit_stat_t;

    // Operator priority
    function automatic logic signed [RANK_W-1:0] rank(input logic [CHAR_W-1:0] c);
        logic signed [RANK_W-1:0] r;
        case (c)
            CH_PLUS:  r = 4'sd1;
            CH_MINUS: r = 4'sd2;
            CH_MUL:   r = 4'sd3;
            CH_DIV:   r = 4'sd4;
            CH_POW:   r = 4'sd5;
            CH_OPEN:  r = -4'sd1;
            CH_CLOSE: r = -4'sd1;
            default:  r = 4'sd0;
        endcase
        return r;
    endfunction

    function automatic logic is_letter(input logic [CHAR_W-1:0] c);
        return ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A));
    endfunction

endpackage

FILE: sv/itp_ram.sv
`timescale 1ns / 1ps

module itp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                                   aclk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // One write port, one registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: sv/itp_emit.sv
`timescale 1ns / 1ps

module itp_emit (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  itp_pkg::emit_req_t           req,
    output itp_pkg::emit_stat_t          stat,
    input  logic                         m_ready,
    output logic                         m_valid,
    output logic [itp_pkg::CHAR_W-1:0]   m_char_out,
    output logic                         m_run_last,
    output logic                         m_expr_done,
    output logic [itp_pkg::ERR_W-1:0]    m_error
);

    // One result is staged until we know whether it is the item's last
    logic                        hold_valid_reg;
    logic [itp_pkg::CHAR_W-1:0]  hold_ch_reg;
    logic [itp_pkg::ERR_W-1:0]   hold_err_reg;

    logic                        m_valid_reg;
    logic [itp_pkg::CHAR_W-1:0]  out_ch_reg;
    logic                        out_last_reg;
    logic                        out_done_reg;
    logic [itp_pkg::ERR_W-1:0]   out_err_reg;

    logic out_free;
    logic load_out;
    logic take_put;
    logic take_close;

    assign out_free      = !m_valid_reg || m_ready;
    assign stat.put_ok   = !hold_valid_reg || out_free;
    assign stat.close_ok = !hold_valid_reg || out_free;
    assign take_put      = req.put && stat.put_ok;
    assign take_close    = req.close && stat.close_ok;
    assign load_out      = hold_valid_reg && out_free && (req.put || req.close);

    // Control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (take_put) begin
                hold_valid_reg <= 1'b1;
            end else if (take_close) begin
                hold_valid_reg <= 1'b0;
            end
        end
    end

    // Payload
    always_ff @(posedge aclk) begin
        if (load_out) begin
            out_ch_reg   <= hold_ch_reg;
            out_err_reg  <= hold_err_reg;
            out_last_reg <= req.close;
            out_done_reg <= req.close && req.done;
        end
        if (take_put) begin
            hold_ch_reg  <= req.ch;
            hold_err_reg <= req.err;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_char_out  = out_ch_reg;
    assign m_run_last  = out_last_reg;
    assign m_expr_done = out_done_reg;
    assign m_error     = out_err_reg;

endmodule

FILE: sv/infix_to_postfix_converter.sv
`timescale 1ns / 1ps

// Channel  | Direction | Ports                                        | Transfer
// input    | in        | s_valid s_ready s_char_in s_expr_end         | s_valid & s_ready
// result   | out       | m_valid m_ready m_char_out m_run_last        | m_valid & m_ready
//          |           | m_expr_done m_error                          |
//
// A letter or a push goes on to S_FLUSH; each character popped also passes S_RELOAD (pop,
// then the registered stack RAM read that refills the cached top), as does the discarded '('.
// An operator that has to pop first also passes S_POPOP's closing rank check and S_PUSH;
// an unmatched ')' gives its error result from S_CLOSE before S_FLUSH.
// Reset clears only the control state and the count; the stack RAM is not cleared.
// One result is staged and one sits in the output register; pops stall while both wait.

module infix_to_postfix_converter #(
    parameter int STACK_DEPTH = 32
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [itp_pkg::CHAR_W-1:0]   s_char_in,
    input  logic                         s_expr_end,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [itp_pkg::CHAR_W-1:0]   m_char_out,
    output logic                         m_run_last,
    output logic                         m_expr_done,
    output logic [itp_pkg::ERR_W-1:0]    m_error
);

    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CW = $clog2(STACK_DEPTH + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CLOSE,
        S_POPOP,
        S_PUSH,
        S_FLUSH,
        S_RELOAD
    } state_t;

    state_t                       state_reg, state_next;
    state_t                       ret_reg, ret_next;
    logic [CW-1:0]                count_reg, count_next;
    logic [itp_pkg::CHAR_W-1:0]   top_reg, top_next;
    logic [itp_pkg::CHAR_W-1:0]   c_reg, c_next;
    logic                         last_reg, last_next;

    itp_pkg::emit_req_t           req;
    itp_pkg::emit_stat_t          stat;

    logic                         push_en;
    logic                         pop_en;
    logic [itp_pkg::CHAR_W-1:0]   push_ch;
    logic [itp_pkg::CHAR_W-1:0]   rd_data;
    logic                         full;
    logic                         empty;

    assign full    = (count_reg >= CW'(STACK_DEPTH));
    assign empty   = (count_reg == '0);
    assign s_ready = (state_reg == S_IDLE);

    // Sequencer
    always_comb begin
        state_next = state_reg;
        ret_next   = ret_reg;
        c_next     = c_reg;
        last_next  = last_reg;
        req        = '0;
        push_en    = 1'b0;
        pop_en     = 1'b0;
        push_ch    = c_reg;

        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    c_next    = s_char_in;
                    last_next = s_expr_end;
                    if (itp_pkg::is_letter(s_char_in)) begin
                        req.put    = 1'b1;
                        req.ch     = s_char_in;
                        req.err    = itp_pkg::ERR_NONE;
                        state_next = S_FLUSH;
                    end else if (s_char_in == itp_pkg::CH_CLOSE) begin
                        state_next = S_CLOSE;
                    end else if ((s_char_in == itp_pkg::CH_OPEN) || empty ||
                                 (itp_pkg::rank(s_char_in) >= itp_pkg::rank(top_reg))) begin
                        // staging is empty here, so a flag always fits
                        push_ch = s_char_in;
                        if (full) begin
                            req.put = 1'b1;
                            req.ch  = itp_pkg::CH_NUL;
                            req.err = itp_pkg::ERR_OVERFLOW;
                        end else begin
                            push_en = 1'b1;
                        end
                        state_next = S_FLUSH;
                    end else begin
                        state_next = S_POPOP;
                    end
                end
            end

            S_CLOSE: begin
                if (!empty && (top_reg != itp_pkg::CH_OPEN)) begin
                    if (stat.put_ok) begin
                        req.put    = 1'b1;
                        req.ch     = top_reg;
                        req.err    = itp_pkg::ERR_NONE;
                        pop_en     = 1'b1;
                        ret_next   = S_CLOSE;
                        state_next = S_RELOAD;
                    end
                end else if (!empty) begin
                    // matching bracket is dropped
                    pop_en     = 1'b1;
                    ret_next   = S_FLUSH;
                    state_next = S_RELOAD;
                end else if (stat.put_ok) begin
                    req.put    = 1'b1;
                    req.ch     = itp_pkg::CH_NUL;
                    req.err    = itp_pkg::ERR_UNMATCHED;
                    state_next = S_FLUSH;
                end
            end

            S_POPOP: begin
                if (!empty && (itp_pkg::rank(top_reg) >= itp_pkg::rank(c_reg))) begin
                    if (stat.put_ok) begin
                        req.put    = 1'b1;
                        req.ch     = top_reg;
                        req.err    = itp_pkg::ERR_NONE;
                        pop_en     = 1'b1;
                        ret_next   = S_POPOP;
                        state_next = S_RELOAD;
                    end
                end else begin
                    state_next = S_PUSH;
                end
            end

            S_PUSH: begin
                if (full) begin
                    if (stat.put_ok) begin
                        req.put    = 1'b1;
                        req.ch     = itp_pkg::CH_NUL;
                        req.err    = itp_pkg::ERR_OVERFLOW;
                        state_next = S_FLUSH;
                    end
                end else begin
                    push_en    = 1'b1;
                    state_next = S_FLUSH;
                end
            end

            S_FLUSH: begin
                if (last_reg && !empty) begin
                    if (stat.put_ok) begin
                        req.put    = 1'b1;
                        req.ch     = top_reg;
                        req.err    = itp_pkg::ERR_NONE;
                        pop_en     = 1'b1;
                        ret_next   = S_FLUSH;
                        state_next = S_RELOAD;
                    end
                end else begin
                    // release the staged result as the item's last
                    req.close = 1'b1;
                    req.done  = last_reg;
                    if (stat.close_ok) begin
                        state_next = S_IDLE;
                    end
                end
            end

            S_RELOAD: begin
                state_next = ret_reg;
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Stack pointer and cached top
    always_comb begin
        count_next = count_reg;
        top_next   = top_reg;
        if (push_en) begin
            count_next = count_reg + CW'(1);
            top_next   = push_ch;
        end else if (pop_en) begin
            count_next = count_reg - CW'(1);
        end else if (state_reg == S_RELOAD) begin
            top_next = rd_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            ret_reg   <= S_IDLE;
            count_reg <= '0;
        end else begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
            count_reg <= count_next;
        end
        top_reg  <= top_next;
        c_reg    <= c_next;
        last_reg <= last_next;
    end

    // Stack store; a pop reads the entry under the old top, which becomes the new top
    itp_ram #(
        .WIDTH (itp_pkg::CHAR_W),
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .aclk  (aclk),
        .we    (push_en),
        .waddr (count_reg[AW-1:0]),
        .wdata (push_ch),
        .re    (pop_en),
        .raddr (AW'(count_reg - CW'(2))),
        .rdata (rd_data)
    );

    itp_emit u_emit (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .req         (req),
        .stat        (stat),
        .m_ready     (m_ready),
        .m_valid     (m_valid),
        .m_char_out  (m_char_out),
        .m_run_last  (m_run_last),
        .m_expr_done (m_expr_done),
        .m_error     (m_error)
    );

endmodule

FILE: sv/itp_checker.sv
`timescale 1ns / 1ps

module itp_checker (
    input logic                         aclk,
    input logic                         aresetn,
    input logic                         s_valid,
    input logic                         s_ready,
    input logic                         m_valid,
    input logic                         m_ready,
    input logic [itp_pkg::CHAR_W-1:0]   m_char_out,
    input logic                         m_run_last,
    input logic                         m_expr_done,
    input logic [itp_pkg::ERR_W-1:0]    m_error
);

    // Only three error codes exist
    a_err_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_error == itp_pkg::ERR_NONE) || (m_error == itp_pkg::ERR_OVERFLOW) ||
                    (m_error == itp_pkg::ERR_UNMATCHED))
        else $error("illegal error code");

    // An error result carries no character
    a_err_char: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_error != itp_pkg::ERR_NONE)) |-> (m_char_out == itp_pkg::CH_NUL))
        else $error("error result with a character");

    // End of expression only on the last result of an item
    a_done_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_expr_done) |-> m_run_last)
        else $error("expr_done without run_last");

    // One item at a time: no transfer right after a transfer
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input taken while busy");

    // A stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_char_out) && $stable(m_error) &&
                                   $stable(m_run_last) && $stable(m_expr_done)))
        else $error("stalled result changed");

endmodule

bind infix_to_postfix_converter itp_checker u_itp_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .s_valid     (s_valid),
    .s_ready     (s_ready),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_char_out  (m_char_out),
    .m_run_last  (m_run_last),
    .m_expr_done (m_expr_done),
    .m_error     (m_error)
);
